FILE: src/u2c_pkg.sv
// Shared types and constants of the UTF-8 to code point filter.
// Used by the channel interfaces, the decode stage, the result serializer and the top level.
package u2c_pkg;

  localparam int ByteW      = 8;
  localparam int PointW     = 21;
  localparam int MaxResults = 3;
  localparam int CountW     = 2;

  localparam logic [ByteW-1:0] ByteNul    = 8'h00;
  localparam logic [ByteW-1:0] ByteTab    = 8'h09;
  localparam logic [ByteW-1:0] ByteCr     = 8'h0D;
  localparam logic [ByteW-1:0] ByteSpace  = 8'h20;
  localparam logic [ByteW-1:0] AsciiMax   = 8'h7F;
  localparam logic [ByteW-1:0] ContMax    = 8'hBF;
  localparam logic [ByteW-1:0] Lead2Max   = 8'hDF;
  localparam logic [ByteW-1:0] Lead3Max   = 8'hEF;
  localparam logic [ByteW-1:0] Lead4Max   = 8'hF7;

  typedef struct packed {
    logic [PointW-1:0] code_point;
    logic              end_marker;
    logic              last_of_run;
  } result_t;

  typedef struct packed {
    result_t [MaxResults-1:0] slot;
    logic    [CountW-1:0]     count;
  } group_t;

endpackage

FILE: src/u2c_byte_if.sv
// Input channel of the filter: one UTF-8 byte per transfer.
// Depends on u2c_pkg.
interface u2c_byte_if;
  logic                        valid;
  logic                        ready;
  logic [u2c_pkg::ByteW-1:0]   byte_in;
  logic                        last_byte;

  modport source (output valid, output byte_in, output last_byte, input ready);
  modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

FILE: src/u2c_point_if.sv
// Output channel of the filter: one code point or end marker per transfer.
// Depends on u2c_pkg.
interface u2c_point_if;
  logic                        valid;
  logic                        ready;
  logic [u2c_pkg::PointW-1:0]  code_point;
  logic                        end_marker;
  logic                        last_of_run;

  modport source (output valid, output code_point, output end_marker, output last_of_run,
                  input ready);
  modport sink   (input valid, input code_point, input end_marker, input last_of_run,
                  output ready);
endinterface

FILE: src/u2c_decode.sv
// Input register, decoder state and the combinational decode of one byte into a result group.
// Depends on u2c_pkg and u2c_byte_if.
module u2c_decode (
  input  logic            clk,
  input  logic            rst,
  u2c_byte_if.sink        bytes,
  output u2c_pkg::group_t grp,
  output logic            grp_valid,
  input  logic            grp_ready
);

  logic                              valid_r;
  logic [u2c_pkg::ByteW-1:0]         byte_r;
  logic                              last_r;

  logic                              held_space;
  logic [1:0]                        bytes_still_expected;
  logic [u2c_pkg::PointW-1:0]        partial_point;

  logic                              held_space_next;
  logic [1:0]                        bytes_still_expected_next;
  logic [u2c_pkg::PointW-1:0]        partial_point_next;

  logic [3:0]                        cand_v;
  logic [u2c_pkg::PointW-1:0]        cand_cp [4];
  logic [u2c_pkg::PointW-1:0]        main_cp;
  logic [u2c_pkg::PointW-1:0]        shifted;
  logic [2:0]                        n;
  logic                              advance;

  assign advance     = valid_r && grp_ready;
  assign bytes.ready = !valid_r || grp_ready;
  assign grp_valid   = valid_r;
  assign shifted     = {partial_point[u2c_pkg::PointW-7:0], byte_r[5:0]};

  always_comb begin
    held_space_next           = held_space;
    bytes_still_expected_next = bytes_still_expected;
    partial_point_next        = partial_point;
    cand_v                    = '0;
    main_cp                   = '0;
    if (bytes_still_expected != 2'd0) begin
      partial_point_next        = shifted;
      bytes_still_expected_next = bytes_still_expected - 2'd1;
      if (bytes_still_expected == 2'd1) begin
        cand_v[1]          = 1'b1;
        main_cp            = shifted;
        partial_point_next = '0;
      end
    end else if (held_space && byte_r == u2c_pkg::ByteSpace) begin
      held_space_next = 1'b1;
    end else begin
      if (held_space) begin
        cand_v[0]       = 1'b1;
        held_space_next = 1'b0;
      end
      priority if (byte_r == u2c_pkg::ByteSpace) begin
        held_space_next = 1'b1;
      end else if (byte_r == u2c_pkg::ByteNul ||
                   (byte_r >= u2c_pkg::ByteTab && byte_r <= u2c_pkg::ByteCr)) begin
        held_space_next = held_space_next;
      end else if (byte_r <= u2c_pkg::AsciiMax) begin
        cand_v[1] = 1'b1;
        main_cp   = {{(u2c_pkg::PointW-u2c_pkg::ByteW){1'b0}}, byte_r};
      end else if (byte_r <= u2c_pkg::ContMax) begin
        held_space_next = held_space_next;
      end else if (byte_r <= u2c_pkg::Lead2Max) begin
        partial_point_next        = {{(u2c_pkg::PointW-5){1'b0}}, byte_r[4:0]};
        bytes_still_expected_next = 2'd1;
      end else if (byte_r <= u2c_pkg::Lead3Max) begin
        partial_point_next        = {{(u2c_pkg::PointW-4){1'b0}}, byte_r[3:0]};
        bytes_still_expected_next = 2'd2;
      end else if (byte_r <= u2c_pkg::Lead4Max) begin
        partial_point_next        = {{(u2c_pkg::PointW-3){1'b0}}, byte_r[2:0]};
        bytes_still_expected_next = 2'd3;
      end else begin
        cand_v[1] = 1'b1;
        main_cp   = '0;
      end
    end
    if (last_r) begin
      cand_v[2]                 = held_space_next;
      cand_v[3]                 = 1'b1;
      held_space_next           = 1'b0;
      bytes_still_expected_next = 2'd0;
      partial_point_next        = '0;
    end
  end

  always_comb begin
    cand_cp[0] = {{(u2c_pkg::PointW-u2c_pkg::ByteW){1'b0}}, u2c_pkg::ByteSpace};
    cand_cp[1] = main_cp;
    cand_cp[2] = {{(u2c_pkg::PointW-u2c_pkg::ByteW){1'b0}}, u2c_pkg::ByteSpace};
    cand_cp[3] = '0;
    grp        = '0;
    n          = 3'd0;
    for (int i = 0; i < 4; i++) begin
      if (cand_v[i] && n < 3'(u2c_pkg::MaxResults)) begin
        grp.slot[n[1:0]].code_point = cand_cp[i];
        grp.slot[n[1:0]].end_marker = (i == 3);
        n = n + 3'd1;
      end
    end
    if (n != 3'd0) begin
      grp.slot[2'(n - 3'd1)].last_of_run = 1'b1;
    end
    grp.count = n[1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_r <= 1'b0;
    end else if (bytes.valid && bytes.ready) begin
      valid_r <= 1'b1;
    end else if (grp_ready) begin
      valid_r <= 1'b0;
    end
    if (bytes.valid && bytes.ready) begin
      byte_r <= bytes.byte_in;
      last_r <= bytes.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_space           <= 1'b0;
      bytes_still_expected <= 2'd0;
      partial_point        <= '0;
    end else if (advance) begin
      held_space           <= held_space_next;
      bytes_still_expected <= bytes_still_expected_next;
      partial_point        <= partial_point_next;
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && last_r) |=> (!held_space && bytes_still_expected == 2'd0 &&
                             partial_point == '0))
    else $error("state not cleared after last byte");

  a_space_or_seq: assert property (@(posedge clk) disable iff (rst)
    (bytes_still_expected != 2'd0) |-> !held_space)
    else $error("held space while a sequence is open");

  a_hold_state: assert property (@(posedge clk) disable iff (rst)
    !$past(advance) |-> ($stable(held_space) && $stable(bytes_still_expected)))
    else $error("decoder state moved without a transfer");

endmodule

FILE: src/u2c_serial.sv
// Result group buffer: takes up to three results at once and sends them out one per transfer.
// Depends on u2c_pkg and u2c_point_if.
module u2c_serial (
  input  logic            clk,
  input  logic            rst,
  input  u2c_pkg::group_t grp,
  input  logic            grp_valid,
  output logic            grp_ready,
  u2c_point_if.source     points
);

  u2c_pkg::result_t [u2c_pkg::MaxResults-1:0] slot;
  logic [u2c_pkg::CountW-1:0]                 cnt;
  logic                                       out_fire;
  logic                                       load;

  assign out_fire           = points.valid && points.ready;
  assign grp_ready          = (cnt == '0) || (cnt == 2'd1 && points.ready);
  assign load               = grp_valid && grp_ready;
  assign points.valid       = (cnt != '0);
  assign points.code_point  = slot[0].code_point;
  assign points.end_marker  = slot[0].end_marker;
  assign points.last_of_run = slot[0].last_of_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= grp.count;
    end else if (out_fire) begin
      cnt <= cnt - 2'd1;
    end
    if (load) begin
      slot <= grp.slot;
    end else if (out_fire) begin
      slot[0] <= slot[1];
      slot[1] <= slot[2];
    end
  end

  a_group_end: assert property (@(posedge clk) disable iff (rst)
    (out_fire && cnt == 2'd1) |-> points.last_of_run)
    else $error("final result of a group lacks last_of_run");

  a_mid_group: assert property (@(posedge clk) disable iff (rst)
    (points.valid && cnt != 2'd1) |-> !points.last_of_run)
    else $error("last_of_run before the group is drained");

  a_load_safe: assert property (@(posedge clk) disable iff (rst)
    load |-> (cnt == '0 || out_fire))
    else $error("group loaded over undelivered results");

endmodule

FILE: src/utf8_to_codepoint_filter_unit.sv
// Top level of the UTF-8 to code point filter: decode stage followed by the result serializer.
// Depends on u2c_pkg, u2c_byte_if, u2c_point_if, u2c_decode and u2c_serial.
//
// Takes one UTF-8 byte per cycle and sends out decoded code points, dropping NUL and the
// tab/LF/VT/FF/CR controls, stray continuation bytes and any space directly followed by
// another space; the byte marked last flushes a held space and adds an end marker. A byte
// is decoded while it sits in the input register, into a group of zero to three results that
// the result buffer loads once it has room, and the results are offered from the result
// buffer's registers; the group then leaves at one result per cycle while the output is
// ready. Bytes are taken every cycle as long as each causes at most one result; a byte that
// causes more than one result keeps the input from taking a further byte until the last
// result of its group is sent, and a stall on the result side holds the input likewise.
module utf8_to_codepoint_filter_unit (
  input  logic        clk,
  input  logic        rst,
  u2c_byte_if.sink    bytes,
  u2c_point_if.source points
);

  u2c_pkg::group_t grp;
  logic            grp_valid;
  logic            grp_ready;

  u2c_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .bytes     (bytes),
    .grp       (grp),
    .grp_valid (grp_valid),
    .grp_ready (grp_ready)
  );

  u2c_serial u_serial (
    .clk       (clk),
    .rst       (rst),
    .grp       (grp),
    .grp_valid (grp_valid),
    .grp_ready (grp_ready),
    .points    (points)
  );

endmodule
